/* hdl/gsq_pkg.sv */
// ----------------------------------------------------------------------------
// gsq_pkg
// Shared types and constants of the gradient stochastic quantizer.
// ----------------------------------------------------------------------------
`default_nettype none
package gsq_pkg;
  localparam int unsigned InvShift = 36;
  localparam int unsigned ValW     = 32;
  localparam int unsigned MagW     = 31;
  localparam int unsigned InvW     = 32;
  localparam int unsigned RndW     = 16;
  localparam int unsigned BinsW    = 8;

  localparam logic [1:0] RegBins  = 2'd0;
  localparam logic [1:0] RegConst = 2'd1;
  localparam logic [1:0] RegLock  = 2'd2;

  localparam logic KindMeasure  = 1'b0;
  localparam logic KindQuantize = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load_in;    // capture input item
    logic meas_upd;   // update running maxima
    logic div_start;  // lock check and start scale division
    logic div_step;   // one division step
    logic div_done;   // write inverse scales
    logic q_mul;      // first quantize stage
    logic q_out;      // build result
  } gsq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic kind;
    logic last;
    logic locked;
  } gsq_sts_t;
endpackage
`default_nettype wire

/* hdl/gsq_datapath.sv */
// ----------------------------------------------------------------------------
// gsq_datapath
// Maxima tracking, restoring dividers for inverse scales, quantize pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module gsq_datapath #(
  parameter int unsigned FRAC_BITS = 24,
  parameter int unsigned RAND_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  gsq_pkg::gsq_cmd_t            cmd_i,
  output gsq_pkg::gsq_sts_t            sts_o,
  input  wire  [gsq_pkg::BinsW-1:0]    quant_bins_i,
  input  wire                          const_hess_i,
  input  wire                          lock_en_i,
  input  wire                          kind_i,
  input  wire  [gsq_pkg::ValW-1:0]     gradient_i,
  input  wire  [gsq_pkg::ValW-1:0]     hessian_i,
  input  wire  [gsq_pkg::RndW-1:0]     grad_rand_i,
  input  wire  [gsq_pkg::RndW-1:0]     hess_rand_i,
  input  wire                          last_i,
  output logic [7:0]                   grad_q_o,
  output logic [7:0]                   hess_q_o,
  output logic                         locked_o,
  output logic                         range_zero_o
);
  import gsq_pkg::*;

  localparam int unsigned NumW = InvShift + 7;  // n < 2^7
  localparam logic [MagW-1:0] OneFix = MagW'(64'd1 << FRAC_BITS);
  localparam logic [MagW-1:0] QtrFix = MagW'(64'd1 << (FRAC_BITS - 2));
  localparam logic [63:0] ThrG = ((64'd16609444 << FRAC_BITS) + 64'd16777215) >> 24;
  localparam logic [63:0] ThrH = ((64'd16642998 << FRAC_BITS) + 64'd67108863) >> 26;
  localparam int unsigned RShift = InvShift - RAND_BITS;

  logic            kind_q, last_q;
  logic [ValW-1:0] g_q, h_q;
  logic [RndW-1:0] gr_q, hr_q;
  logic [MagW-1:0] maxg_q, maxh_q;
  logic            open_q, locked_q;
  logic [InvW-1:0] invg_q, invh_q;

  logic [NumW-1:0] ng_q, nh_q;      // dividend shift registers
  logic [NumW-1:0] qg_q, qh_q;      // quotients
  logic [MagW:0]   rg_q, rh_q;      // partial remainders

  logic [63:0] pg_q, ph_q;
  logic        negg_q, negh_q;

  function automatic logic [MagW-1:0] abs31(input logic [ValW-1:0] v);
    logic [ValW-1:0] m;
    m = v[ValW-1] ? (~v + ValW'(1)) : v;
    return m[ValW-1] ? {MagW{1'b1}} : m[MagW-1:0];
  endfunction

  function automatic logic [7:0] sat8(input logic [63:0] p, input logic neg,
                                      input logic [RndW-1:0] r);
    logic [64:0] s;
    logic [64:0] q;
    logic [7:0]  m;
    s = {1'b0, p} + (65'(r) << RShift);
    q = s >> InvShift;
    if (neg) begin
      m = (q > 65'd128) ? 8'd128 : q[7:0];
      return 8'd0 - m;
    end
    return (q > 65'd127) ? 8'd127 : q[7:0];
  endfunction

  function automatic logic [InvW-1:0] satq(input logic [NumW-1:0] q);
    return (q > NumW'({InvW{1'b1}})) ? {InvW{1'b1}} : q[InvW-1:0];
  endfunction

  logic [MagW-1:0] ga, ha, ng_sel, nh_sel;
  logic [ValW-1:0] gm, hm;
  logic            do_lock;
  logic [MagW:0]   rg_sh, rh_sh;
  logic            zero;

  assign ga = abs31(g_q);
  assign ha = abs31(h_q);
  // quantize uses the unsaturated magnitude, -2^31 gives 2^31
  assign gm = g_q[ValW-1] ? (~g_q + ValW'(1)) : g_q;
  assign hm = h_q[ValW-1] ? (~h_q + ValW'(1)) : h_q;
  assign do_lock = lock_en_i && (64'(maxg_q) >= ThrG) && (64'(maxh_q) >= ThrH);
  assign ng_sel = do_lock ? OneFix : maxg_q;
  assign nh_sel = do_lock ? QtrFix : maxh_q;
  assign rg_sh = {rg_q[MagW-1:0], ng_q[NumW-1]};
  assign rh_sh = {rh_q[MagW-1:0], nh_q[NumW-1]};
  assign zero = (maxg_q == '0) || (!const_hess_i && maxh_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxg_q <= '0;
      maxh_q <= '0;
      open_q <= 1'b0;
      locked_q <= 1'b0;
      invg_q <= '0;
      invh_q <= '0;
    end else begin
      if (cmd_i.meas_upd) begin
        if (!open_q || ga > maxg_q) maxg_q <= ga;
        if (!open_q || ha > maxh_q) maxh_q <= ha;
        open_q <= 1'b1;
      end
      if (cmd_i.div_start) begin
        maxg_q <= ng_sel;
        maxh_q <= nh_sel;
        if (do_lock) locked_q <= 1'b1;
        open_q <= 1'b0;
      end
      if (cmd_i.div_done) begin
        invg_q <= (maxg_q == '0) ? '0 : satq(qg_q);
        invh_q <= (maxh_q == '0) ? '0 : satq(qh_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q <= kind_i;
      last_q <= last_i;
      g_q <= gradient_i;
      h_q <= hessian_i;
      gr_q <= grad_rand_i;
      hr_q <= hess_rand_i;
    end
    if (cmd_i.div_start) begin
      ng_q <= NumW'({quant_bins_i >> 1}) << InvShift;
      nh_q <= NumW'(const_hess_i ? 2'd1 : 2'd2) << InvShift;
      qg_q <= '0;
      qh_q <= '0;
      rg_q <= '0;
      rh_q <= '0;
    end
    if (cmd_i.div_step) begin
      ng_q <= ng_q << 1;
      nh_q <= nh_q << 1;
      if (rg_sh >= {1'b0, maxg_q} && maxg_q != '0) begin
        rg_q <= rg_sh - {1'b0, maxg_q};
        qg_q <= {qg_q[NumW-2:0], 1'b1};
      end else begin
        rg_q <= rg_sh;
        qg_q <= {qg_q[NumW-2:0], 1'b0};
      end
      if (rh_sh >= {1'b0, maxh_q} && maxh_q != '0) begin
        rh_q <= rh_sh - {1'b0, maxh_q};
        qh_q <= {qh_q[NumW-2:0], 1'b1};
      end else begin
        rh_q <= rh_sh;
        qh_q <= {qh_q[NumW-2:0], 1'b0};
      end
    end
    if (cmd_i.q_mul) begin
      pg_q <= 64'(gm) * 64'(invg_q);
      ph_q <= 64'(hm) * 64'(invh_q);
      negg_q <= g_q[ValW-1];
      negh_q <= h_q[ValW-1];
    end
    if (cmd_i.q_out) begin
      range_zero_o <= zero;
      locked_o <= locked_q;
      grad_q_o <= zero ? 8'd0 : sat8(pg_q, negg_q, gr_q);
      hess_q_o <= const_hess_i ? 8'd1 : (zero ? 8'd0 : sat8(ph_q, negh_q, hr_q));
    end
  end

  assign sts_o = '{kind: kind_q, last: last_q, locked: locked_q};
endmodule
`default_nettype wire

/* hdl/gsq_ctrl.sv */
// ----------------------------------------------------------------------------
// gsq_ctrl
// Sequencer: input capture, measure, scale division, quantize, output hold.
// ----------------------------------------------------------------------------
`default_nettype none
module gsq_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                s_valid_i,
  output logic               s_ready_o,
  output logic               m_valid_o,
  input  wire                m_ready_i,
  output gsq_pkg::gsq_cmd_t  cmd_o,
  input  gsq_pkg::gsq_sts_t  sts_i
);
  import gsq_pkg::*;

  localparam int unsigned DivSteps = InvShift + 7;

  typedef enum logic [2:0] {
    StIdle, StDecode, StDivStart, StDiv, StDivDone, StMul, StOut, StHold
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        mv_q, mv_d;

  assign s_ready_o = (state_q == StIdle) && (!mv_q || m_ready_i);
  assign m_valid_o = mv_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    mv_d = mv_q;
    cmd_o = '0;
    if (mv_q && m_ready_i) mv_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (s_valid_i && s_ready_o) begin
          cmd_o.load_in = 1'b1;
          state_d = StDecode;
        end
      end
      StDecode: begin
        if (sts_i.kind == KindQuantize) state_d = StMul;
        else if (sts_i.locked) state_d = StIdle;
        else begin
          cmd_o.meas_upd = 1'b1;
          state_d = sts_i.last ? StDivStart : StIdle;
        end
      end
      StDivStart: begin
        cmd_o.div_start = 1'b1;
        cnt_d = '0;
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DivSteps - 1)) state_d = StDivDone;
      end
      StDivDone: begin
        cmd_o.div_done = 1'b1;
        state_d = StIdle;
      end
      StMul: begin
        cmd_o.q_mul = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!mv_d) begin
          cmd_o.q_out = 1'b1;
          mv_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      mv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      mv_q <= mv_d;
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("multiple commands");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_ready_o |-> state_q == StIdle) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv_q && !m_ready_i) |=> mv_q) else $error("result dropped");
endmodule
`default_nettype wire

/* hdl/gradient_stochastic_quantizer.sv */
// ----------------------------------------------------------------------------
// gradient_stochastic_quantizer
// Two-pass stochastic int8 quantizer for gradient/hessian pairs.
// ----------------------------------------------------------------------------
// Measure item: updates the running maxima unless locked; the last one then runs
// a bit-per-cycle restoring division of the inverse scales.
// Quantize item: next item accepted once the result is registered and not stalled.
// Result register holds while m_axis_tready is low.
// Reset clears maxima, scales, lock and registers (quant_bins 4).
`default_nettype none
module gradient_stochastic_quantizer #(
  parameter int unsigned FRAC_BITS = 24,
  parameter int unsigned RAND_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [95:0] s_axis_tdata,   // gradient, hessian, grad_rand, hess_rand
  input  wire         s_axis_tuser,   // kind
  input  wire         s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // grad_q, hess_q
  output logic [1:0]  m_axis_tuser    // locked_flag, range_zero
);
  import gsq_pkg::*;

  logic [BinsW-1:0] bins_q;
  logic             const_q, lock_en_q;
  logic             wr;
  gsq_cmd_t         cmd;
  gsq_sts_t         sts;
  logic             lk, rz;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= BinsW'(4);
      const_q <= 1'b0;
      lock_en_q <= 1'b0;
    end else if (wr) begin
      case (paddr[3:2])
        RegBins:  bins_q <= pwdata[BinsW-1:0];
        RegConst: const_q <= pwdata[0];
        RegLock:  lock_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegBins:  prdata = 32'(bins_q);
      RegConst: prdata = 32'(const_q);
      RegLock:  prdata = 32'(lock_en_q);
      default:  prdata = '0;
    endcase
  end

  gsq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .cmd_o(cmd), .sts_i(sts)
  );

  gsq_datapath #(.FRAC_BITS(FRAC_BITS), .RAND_BITS(RAND_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .quant_bins_i(bins_q), .const_hess_i(const_q), .lock_en_i(lock_en_q),
    .kind_i(s_axis_tuser),
    .gradient_i(s_axis_tdata[31:0]), .hessian_i(s_axis_tdata[63:32]),
    .grad_rand_i(s_axis_tdata[79:64]), .hess_rand_i(s_axis_tdata[95:80]),
    .last_i(s_axis_tlast),
    .grad_q_o(m_axis_tdata[7:0]), .hess_q_o(m_axis_tdata[15:8]),
    .locked_o(lk), .range_zero_o(rz)
  );

  assign m_axis_tuser = {rz, lk};
endmodule
`default_nettype wire
